[rtl/ntfd_pkg.sv]
// ----------------------------------------------------------------------------
// ntfd_pkg
// Shared types and constants of the nibble text frame deframer.
// ----------------------------------------------------------------------------
package ntfd_pkg;

  localparam int MAX_DATA_DEF    = 14;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] END_BYTE    = 8'h7D;
  localparam logic [7:0] ESC_BYTE    = 8'h7C;
  localparam logic [7:0] DIGIT_BASE  = 8'h30;
  localparam logic [7:0] MARK_FIRST  = 8'h37;
  localparam logic [7:0] MARK_SECOND = 8'h3B;

  typedef enum logic [1:0] {
    KIND_ID     = 2'd0,
    KIND_LENGTH = 2'd1,
    KIND_DATA   = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    HUNT_IDLE  = 2'd0,
    HUNT_SAW7  = 2'd1,
    HUNT_FRAME = 2'd2
  } hunt_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  byte_value;
    logic [3:0]  position;
    logic        parsed_ok;
    logic        frame_end;
  } res_t;

endpackage

[rtl/ntfd_front.sv]
// ----------------------------------------------------------------------------
// ntfd_front
// Marker hunt, character pairing and byte classification; one item a cycle.
// ----------------------------------------------------------------------------
module ntfd_front #(
  parameter int MAX_DATA = ntfd_pkg::MAX_DATA_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [7:0]    character,
  output logic          res_valid,
  output ntfd_pkg::res_t res
);
  import ntfd_pkg::*;

  hunt_t       hunt, hunt_next;
  logic        pair_phase, pair_phase_next;
  logic [7:0]  high_part, high_part_next;
  logic        escape_flag, escape_flag_next;
  logic [7:0]  frame_id, frame_id_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [3:0]  data_count, data_count_next;
  logic        success_flag, success_flag_next;

  logic [7:0]  high_off;
  logic [7:0]  low_off;
  logic [7:0]  value;
  logic [3:0]  count_inc;

  assign high_off  = high_part - DIGIT_BASE;
  assign low_off   = character - DIGIT_BASE;
  assign value     = {high_off[3:0], 4'h0} | low_off;
  assign count_inc = data_count + 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hunt         <= HUNT_IDLE;
      pair_phase   <= 1'b0;
      high_part    <= '0;
      escape_flag  <= 1'b0;
      frame_id     <= '0;
      frame_length <= '0;
      data_count   <= '0;
      success_flag <= 1'b0;
    end else begin
      hunt         <= hunt_next;
      pair_phase   <= pair_phase_next;
      high_part    <= high_part_next;
      escape_flag  <= escape_flag_next;
      frame_id     <= frame_id_next;
      frame_length <= frame_length_next;
      data_count   <= data_count_next;
      success_flag <= success_flag_next;
    end
  end

  always_comb begin
    hunt_next         = hunt;
    pair_phase_next   = pair_phase;
    high_part_next    = high_part;
    escape_flag_next  = escape_flag;
    frame_id_next     = frame_id;
    frame_length_next = frame_length;
    data_count_next   = data_count;
    success_flag_next = success_flag;
    res_valid         = 1'b0;
    res               = '0;

    if (in_valid) begin
      case (hunt)
        HUNT_SAW7: begin
          if (character == MARK_SECOND) begin
            hunt_next         = HUNT_FRAME;
            pair_phase_next   = 1'b0;
            high_part_next    = '0;
            escape_flag_next  = 1'b0;
            frame_id_next     = '0;
            frame_length_next = '0;
            data_count_next   = '0;
            success_flag_next = 1'b0;
          end else if (character != MARK_FIRST) begin
            hunt_next = HUNT_IDLE;
          end
        end
        HUNT_FRAME: begin
          if (!pair_phase) begin
            high_part_next  = character;
            pair_phase_next = 1'b1;
          end else begin
            pair_phase_next = 1'b0;
            if (value == END_BYTE) begin
              res_valid      = 1'b1;
              res.kind       = KIND_END;
              res.byte_value = END_BYTE;
              res.position   = data_count;
              res.parsed_ok  = success_flag;
              res.frame_end  = 1'b1;
              hunt_next      = HUNT_IDLE;
            end else if (!escape_flag && value == ESC_BYTE) begin
              escape_flag_next = 1'b1;
            end else if (frame_id == 8'd0) begin
              // a zero id still reads as not taken
              frame_id_next    = value;
              escape_flag_next = 1'b0;
              res_valid        = 1'b1;
              res.kind         = KIND_ID;
              res.byte_value   = value;
              res.parsed_ok    = success_flag;
            end else if (frame_length == 8'd0) begin
              frame_length_next = value;
              escape_flag_next  = 1'b0;
              res_valid         = 1'b1;
              res.kind          = KIND_LENGTH;
              res.byte_value    = value;
              res.parsed_ok     = success_flag;
            end else if ({4'd0, data_count} < frame_length) begin
              data_count_next  = count_inc;
              escape_flag_next = 1'b0;
              if ({4'd0, count_inc} < frame_length) begin
                success_flag_next = 1'b1;
              end
              res_valid      = 1'b1;
              res.kind       = KIND_DATA;
              res.byte_value = value;
              res.position   = data_count;
              res.parsed_ok  = success_flag_next;
              res.frame_end  = (count_inc >= 4'(MAX_DATA));
              if (count_inc >= 4'(MAX_DATA)) begin
                hunt_next = HUNT_IDLE;
              end
            end
            // bytes past the declared length drop silently
          end
        end
        default: begin
          hunt_next = (character == MARK_FIRST) ? HUNT_SAW7 : HUNT_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/ntfd_queue.sv]
// ----------------------------------------------------------------------------
// ntfd_queue
// Short result queue between the classifier and the result port.
// ----------------------------------------------------------------------------
module ntfd_queue #(
  parameter int DEPTH = ntfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  ntfd_pkg::res_t wr_data,
  input  logic           rd_en,
  output ntfd_pkg::res_t rd_data,
  output logic           full,
  output logic           empty
);
  import ntfd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  res_t            slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr;
  logic            do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/nibble_text_frame_deframer_core.sv]
// ----------------------------------------------------------------------------
// nibble_text_frame_deframer_core
// Deframes a text character stream into id, length, data and end items.
// ----------------------------------------------------------------------------
// Input side: drive character with push; an item is taken at a clock edge
// where push is high and full is low; one character per cycle while not full.
// Result side: while empty is low the oldest result sits on kind,
// byte_value, position, parsed_ok and frame_end; pop takes it.
// A result enters the queue on the same edge its closing character is
// taken; it is registered in a queue slot and shows on the ports once all
// older results are popped. Many characters give no result (hunting, high
// characters, escapes, bytes past the length).
// Throughput is one character per cycle while full is low, set by the
// classifier's single stage of state registers; the result queue (QUEUE_DEPTH
// entries) lets the receiver stall; full rises only at QUEUE_DEPTH results.
// Reset clears the hunt state and empties the queue; the block accepts a
// character in the first cycle after reset.
// ----------------------------------------------------------------------------
module nibble_text_frame_deframer_core #(
  parameter int MAX_DATA    = ntfd_pkg::MAX_DATA_DEF,
  parameter int QUEUE_DEPTH = ntfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] character,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind,
  output logic [7:0] byte_value,
  output logic [3:0] position,
  output logic       parsed_ok,
  output logic       frame_end
);
  import ntfd_pkg::*;

  logic in_valid;
  logic res_valid;
  res_t res;
  res_t head;

  assign in_valid = push && !full;

  ntfd_front #(
    .MAX_DATA (MAX_DATA)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .character (character),
    .res_valid (res_valid),
    .res       (res)
  );

  ntfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_data (res),
    .rd_en   (pop),
    .rd_data (head),
    .full    (full),
    .empty   (empty)
  );

  assign kind       = head.kind;
  assign byte_value = head.byte_value;
  assign position   = head.position;
  assign parsed_ok  = head.parsed_ok;
  assign frame_end  = head.frame_end;

endmodule
